>>> src/mrfp_pkg.sv
// Shared types and constants for the motor response frame parser.
package mrfp_pkg;

    localparam logic [7:0] SUFFIX_BYTE   = 8'h6B;
    localparam logic [7:0] FN_POSITION   = 8'h36;
    localparam logic [7:0] CODE_ACCEPTED = 8'h02;
    localparam logic [7:0] CODE_REACHED  = 8'h9F;
    localparam logic [7:0] CODE_PROT_A   = 8'hE2;
    localparam logic [7:0] CODE_PROT_B   = 8'hEE;

    localparam logic [3:0] LEN_UNKNOWN   = 4'd0;
    localparam logic [3:0] LEN_CONTROL   = 4'd4;
    localparam logic [3:0] LEN_POSITION  = 4'd8;

    // bytes held before the closing byte of the longest frame
    localparam int unsigned BUF_DEPTH    = 7;

    localparam logic [7:0] DEV_ADDR_RESET = 8'h01;
    localparam int unsigned REG_DEVICE_ADDRESS = 0;

    typedef enum logic [2:0] {
        KIND_NONE       = 3'd0,
        KIND_POSITION   = 3'd1,
        KIND_ACCEPTED   = 3'd2,
        KIND_REACHED    = 3'd3,
        KIND_PROTECTION = 3'd4,
        KIND_PROTOCOL   = 3'd5
    } kind_t;

    typedef logic [BUF_DEPTH-1:0][7:0] frame_bytes_t;

    typedef struct packed {
        kind_t       kind;
        logic        pos_we;
        logic [31:0] pos_value;
        logic        ctrl_we;
    } decode_t;

endpackage

>>> src/motor_response_frame_parser.sv
// Top level of the motor response frame parser: byte tracking, state and handshakes.
//
//   channel   direction  handshake                 payload
//   rx        in         in_valid / in_stall       rx_byte
//   response  out        out_valid / out_stall     response_kind, position, position_count,
//                                                  control_function, control_code
//   config    in         APB psel/penable/pwrite   device_address at offset 0
//
// One request per cycle sustained while the result is not stalled; each byte is held in the input
// register and is decoded on its way into the result register.
// Reset clears the parser, the position, counters and records; device_address goes to 1.
// A stalled result holds its register; the input register still takes one more request.
module motor_response_frame_parser
    import mrfp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          response_kind,
    output logic signed [31:0]  position,
    output logic [31:0]         position_count,
    output logic [7:0]          control_function,
    output logic [7:0]          control_code,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    kind_t        kind_reg;
    kind_t        kind_next;

    logic [7:0]   device_address_reg;
    logic [3:0]   byte_count_reg;
    logic [3:0]   byte_count_next;
    logic [3:0]   frame_length_reg;
    logic [3:0]   frame_length_next;
    frame_bytes_t frame_reg;
    logic [31:0]  position_reg;
    logic [31:0]  position_counter_reg;
    logic [7:0]   last_function_reg;
    logic [7:0]   last_code_reg;

    logic         advance;
    logic         accept;
    logic         process;
    logic         take;
    logic [3:0]   count_inc;
    logic         done;
    logic         cfg_write;
    decode_t      dec;

    // ---------------- handshakes ----------------
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign process  = advance && in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_NONE;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                kind_reg      <= kind_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= rx_byte;
    end

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == 1'(REG_DEVICE_ADDRESS));
    assign prdata    = (paddr[2] == 1'(REG_DEVICE_ADDRESS)) ? {24'd0, device_address_reg}
                                                             : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            device_address_reg <= DEV_ADDR_RESET;
        else if (cfg_write)
            device_address_reg <= pwdata[7:0];
    end

    // ---------------- frame tracking ----------------
    assign take      = (byte_count_reg != 4'd0) || (in_byte_reg == device_address_reg);
    assign count_inc = byte_count_reg + 4'd1;
    assign done      = take && (frame_length_reg != LEN_UNKNOWN)
                       && (count_inc >= frame_length_reg);

    mrfp_decode u_decode (
        .frame     (frame_reg),
        .last_byte (in_byte_reg),
        .dev_addr  (device_address_reg),
        .frame_len (frame_length_reg),
        .result    (dec)
    );

    always_comb
    begin
        byte_count_next   = byte_count_reg;
        frame_length_next = frame_length_reg;
        kind_next         = KIND_NONE;
        if (take)
        begin
            byte_count_next = count_inc;
            if (count_inc == 4'd2)
                frame_length_next = (in_byte_reg == FN_POSITION) ? LEN_POSITION : LEN_CONTROL;
            if (done)
            begin
                kind_next         = dec.kind;
                byte_count_next   = 4'd0;
                frame_length_next = LEN_UNKNOWN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg       <= 4'd0;
            frame_length_reg     <= LEN_UNKNOWN;
            position_reg         <= 32'd0;
            position_counter_reg <= 32'd0;
            last_function_reg    <= 8'd0;
            last_code_reg        <= 8'd0;
        end
        else if (process)
        begin
            byte_count_reg   <= byte_count_next;
            frame_length_reg <= frame_length_next;
            if (done && dec.pos_we)
            begin
                position_reg         <= dec.pos_value;
                position_counter_reg <= position_counter_reg + 32'd1;
            end
            if (done && dec.ctrl_we)
            begin
                last_function_reg <= frame_reg[1];
                last_code_reg     <= frame_reg[2];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && take && (byte_count_reg < 4'(BUF_DEPTH)))
            frame_reg[byte_count_reg[2:0]] <= in_byte_reg;
    end

    // state only moves when the result register loads, so it matches the held result
    assign out_valid        = out_valid_reg;
    assign response_kind    = kind_reg;
    assign position         = position_reg;
    assign position_count   = position_counter_reg;
    assign control_function = last_function_reg;
    assign control_code     = last_code_reg;

    // ---------------- assertions ----------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg < 4'd8)
        else $error("byte count out of range");

    a_len_known: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_count_reg >= 4'd2) == (frame_length_reg != LEN_UNKNOWN))
        else $error("frame length not in step with byte count");

    a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
        frame_length_reg == LEN_UNKNOWN || frame_length_reg == LEN_CONTROL
        || frame_length_reg == LEN_POSITION)
        else $error("illegal frame length");

    a_pos_count: assert property (@(posedge clk) disable iff (!rst_n)
        (process && kind_next == KIND_POSITION)
        |=> (position_counter_reg == $past(position_counter_reg) + 32'd1)
            && (kind_reg == KIND_POSITION))
        else $error("position reply did not advance the counter");

endmodule

>>> src/mrfp_decode.sv
// Decode of a completed response frame: suffix/address check, position and status sort.
module mrfp_decode
    import mrfp_pkg::*;
(
    input  frame_bytes_t frame,
    input  logic [7:0]   last_byte,
    input  logic [7:0]   dev_addr,
    input  logic [3:0]   frame_len,
    output decode_t      result
);

    logic        frame_ok;
    logic [31:0] magnitude;
    logic [7:0]  code;

    assign frame_ok  = (frame[0] == dev_addr) && (last_byte == SUFFIX_BYTE);
    assign magnitude = {frame[3], frame[4], frame[5], frame[6]};
    assign code      = frame[2];

    always_comb
    begin
        result.kind      = KIND_PROTOCOL;
        result.pos_we    = 1'b0;
        result.pos_value = (code != 8'd0) ? (32'd0 - magnitude) : magnitude;
        result.ctrl_we   = 1'b0;
        if (frame_len == LEN_POSITION)
        begin
            if (frame_ok)
            begin
                result.kind   = KIND_POSITION;
                result.pos_we = 1'b1;
            end
        end
        else if (frame_ok)
        begin
            result.ctrl_we = 1'b1;
            case (code) inside
                CODE_ACCEPTED:            result.kind = KIND_ACCEPTED;
                CODE_REACHED:             result.kind = KIND_REACHED;
                CODE_PROT_A, CODE_PROT_B: result.kind = KIND_PROTECTION;
                default:                  result.kind = KIND_PROTOCOL;
            endcase
        end
    end

endmodule
